>>> rtl/keyboard_escape_sequence_decoder_core_assert.svh
// assertion helpers used by the decoder core
`ifndef KEYBOARD_ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH
`define KEYBOARD_ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define KESD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define KESD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/kesd_pkg.sv
package kesd_pkg;

	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_RIGHT      = 4'd1,
		ACT_LEFT       = 4'd2,
		ACT_UP         = 4'd3,
		ACT_DOWN       = 4'd4,
		ACT_SHIFT_LEFT  = 4'd5,
		ACT_SELECT     = 4'd6,
		ACT_SHIFT_RIGHT = 4'd7,
		ACT_LINE_DONE  = 4'd8,
		ACT_EXIT       = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		EDIT_NONE   = 2'd0,
		EDIT_APPEND = 2'd1,
		EDIT_DELETE = 2'd2
	} edit_kind_t;

	localparam logic [7:0] KEY_BS        = 8'd8;
	localparam logic [7:0] KEY_LF        = 8'd10;
	localparam logic [7:0] KEY_CR        = 8'd13;
	localparam logic [7:0] KEY_ESC       = 8'd27;
	localparam logic [7:0] KEY_SPACE     = 8'h20;
	localparam logic [7:0] KEY_DIGIT_0   = 8'h30;
	localparam logic [7:0] KEY_DIGIT_1   = 8'h31;
	localparam logic [7:0] KEY_DIGIT_2   = 8'h32;
	localparam logic [7:0] KEY_DIGIT_5   = 8'h35;
	localparam logic [7:0] KEY_DIGIT_9   = 8'h39;
	localparam logic [7:0] KEY_UPPER_A   = 8'h41;
	localparam logic [7:0] KEY_UPPER_B   = 8'h42;
	localparam logic [7:0] KEY_UPPER_C   = 8'h43;
	localparam logic [7:0] KEY_UPPER_D   = 8'h44;
	localparam logic [7:0] KEY_UPPER_Z   = 8'h5A;
	localparam logic [7:0] KEY_BRACKET   = 8'd91;
	localparam logic [7:0] KEY_BACKQUOTE = 8'h60;
	localparam logic [7:0] KEY_LOWER_A   = 8'h61;
	localparam logic [7:0] KEY_LOWER_Z   = 8'h7A;
	localparam logic [7:0] KEY_TILDE     = 8'h7E;
	localparam logic [7:0] KEY_DEL       = 8'd127;

	typedef struct packed {
		logic [7:0] key_byte;
		logic       clear_buffer;
	} key_item_t;

	typedef struct packed {
		cmd_t       command;
		edit_kind_t edit_kind;
		logic [7:0] edit_char;
		logic [4:0] edit_position;
		logic [5:0] typed_length;
	} res_item_t;

	typedef struct packed {
		logic       clear;
		edit_kind_t op;
	} line_req_t;

	typedef struct packed {
		edit_kind_t kind;
		logic [4:0] position;
		logic [5:0] length;
	} line_rsp_t;

endpackage

>>> rtl/kesd_line.sv
module kesd_line #(
	parameter int MAX_TYPED_CHARS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  kesd_pkg::line_req_t req,
	output kesd_pkg::line_rsp_t rsp
);

	localparam int LEN_W = $clog2(MAX_TYPED_CHARS + 1);

	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     len_base;
	logic [LEN_W-1:0]     len_next;
	logic [LEN_W-1:0]     pos;
	logic [LEN_W+5:0]     len_ext;
	logic [LEN_W+5:0]     pos_ext;
	kesd_pkg::edit_kind_t kind_d;

	// clear acts before the byte's own edit
	assign len_base = req.clear ? '0 : len_q;

	always_comb begin
		len_next = len_base;
		pos      = '0;
		kind_d   = kesd_pkg::EDIT_NONE;
		case (req.op)
			kesd_pkg::EDIT_APPEND: begin
				if (len_base < LEN_W'(MAX_TYPED_CHARS)) begin
					kind_d   = kesd_pkg::EDIT_APPEND;
					pos      = len_base;
					len_next = len_base + LEN_W'(1);
				end
			end
			kesd_pkg::EDIT_DELETE: begin
				if (len_base != '0) begin
					kind_d   = kesd_pkg::EDIT_DELETE;
					len_next = len_base - LEN_W'(1);
					pos      = len_next;
				end
			end
			default: ;
		endcase
	end

	// reported fields are the low bits of the count
	assign len_ext = {6'd0, len_next};
	assign pos_ext = {6'd0, pos};
	assign rsp     = '{kind: kind_d, position: pos_ext[4:0], length: len_ext[5:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (step) begin
			len_q <= len_next;
		end
	end

endmodule

>>> rtl/keyboard_escape_sequence_decoder_core.sv
// path: an accepted item is held in the input register, and its result is written
// into the result register through the decode logic once that register is free
// throughput: one item per cycle while res is taken; the result register frees as soon as res is taken
// reset: arst_n clears the escape decoder to idle, empties the line and drops
// any item in flight
module keyboard_escape_sequence_decoder_core #(
	parameter int MAX_TYPED_CHARS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_valid,
	output logic                key_ready,
	input  kesd_pkg::key_item_t key_item,
	output logic                res_valid,
	input  logic                res_ready,
	output kesd_pkg::res_item_t res_item
);

	`include "keyboard_escape_sequence_decoder_core_assert.svh"

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ESC   = 2'd1,
		PH_BRACK = 2'd2,
		PH_TILDE = 2'd3
	} phase_t;

	phase_t              phase_q;
	phase_t              phase_next;
	logic                item_valid_s1;
	kesd_pkg::key_item_t item_s1;
	logic                res_valid_q;
	kesd_pkg::res_item_t res_q;
	logic                advance;
	logic                plain;
	logic [7:0]          b;
	kesd_pkg::cmd_t      cmd;
	kesd_pkg::line_req_t line_req;
	kesd_pkg::line_rsp_t line_rsp;

	function automatic logic is_text(input logic [7:0] c);
		return (c >= kesd_pkg::KEY_UPPER_A && c <= kesd_pkg::KEY_UPPER_Z) ||
			(c >= kesd_pkg::KEY_LOWER_A && c <= kesd_pkg::KEY_LOWER_Z) ||
			(c >= kesd_pkg::KEY_DIGIT_0 && c <= kesd_pkg::KEY_DIGIT_9) ||
			(c == kesd_pkg::KEY_SPACE);
	endfunction

	assign advance   = item_valid_s1 && (!res_valid_q || res_ready);
	assign key_ready = !item_valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;
	assign b         = item_s1.key_byte;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (key_ready) begin
			item_valid_s1 <= key_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_ready && key_valid) begin
			item_s1 <= key_item;
		end
	end

	// escape decoder and plain byte classification
	always_comb begin
		phase_next     = phase_q;
		cmd            = kesd_pkg::ACT_NONE;
		plain          = 1'b0;
		line_req.clear = item_s1.clear_buffer;
		line_req.op    = kesd_pkg::EDIT_NONE;
		if (b == kesd_pkg::KEY_BACKQUOTE) begin
			cmd = kesd_pkg::ACT_EXIT;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (b == kesd_pkg::KEY_ESC) begin
						phase_next = PH_ESC;
					end else begin
						plain = 1'b1;
					end
				end
				PH_ESC: begin
					if (b == kesd_pkg::KEY_BRACKET) begin
						phase_next = PH_BRACK;
					end else begin
						phase_next = PH_IDLE;
						plain      = 1'b1;
					end
				end
				PH_BRACK: begin
					phase_next = PH_IDLE;
					unique case (b) inside
						kesd_pkg::KEY_UPPER_A: cmd = kesd_pkg::ACT_UP;
						kesd_pkg::KEY_UPPER_B: cmd = kesd_pkg::ACT_DOWN;
						kesd_pkg::KEY_UPPER_C: cmd = kesd_pkg::ACT_RIGHT;
						kesd_pkg::KEY_UPPER_D: cmd = kesd_pkg::ACT_LEFT;
						kesd_pkg::KEY_DIGIT_1: begin
							cmd        = kesd_pkg::ACT_SELECT;
							phase_next = PH_TILDE;
						end
						kesd_pkg::KEY_DIGIT_2: begin
							cmd        = kesd_pkg::ACT_SHIFT_LEFT;
							phase_next = PH_TILDE;
						end
						kesd_pkg::KEY_DIGIT_5: begin
							cmd        = kesd_pkg::ACT_SHIFT_RIGHT;
							phase_next = PH_TILDE;
						end
						default: plain = 1'b1;
					endcase
				end
				PH_TILDE: begin
					phase_next = PH_IDLE;
					plain      = (b != kesd_pkg::KEY_TILDE);
				end
				default: phase_next = PH_IDLE;
			endcase
		end
		if (plain) begin
			case (b) inside
				kesd_pkg::KEY_BS, kesd_pkg::KEY_DEL: line_req.op = kesd_pkg::EDIT_DELETE;
				kesd_pkg::KEY_LF, kesd_pkg::KEY_CR:  cmd = kesd_pkg::ACT_LINE_DONE;
				default: begin
					if (is_text(b)) begin
						line_req.op = kesd_pkg::EDIT_APPEND;
					end
				end
			endcase
		end
	end

	kesd_line #(
		.MAX_TYPED_CHARS(MAX_TYPED_CHARS)
	) u_line (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.req   (line_req),
		.rsp   (line_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_next;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.command       <= cmd;
			res_q.edit_kind     <= line_rsp.kind;
			res_q.edit_char     <= (line_rsp.kind == kesd_pkg::EDIT_APPEND) ? b : 8'd0;
			res_q.edit_position <= line_rsp.position;
			res_q.typed_length  <= line_rsp.length;
		end
	end

	`KESD_ASSERT_NOW(a_ready_when_free, (!res_valid_q || res_ready), key_ready,
		"input stalled although result register is free")
	`KESD_ASSERT_NEXT(a_tilde_returns_idle,
		(advance && phase_q == PH_TILDE && b != kesd_pkg::KEY_BACKQUOTE),
		(phase_q == PH_IDLE), "decoder did not leave tilde phase")
	`KESD_ASSERT_NOW(a_quit_no_edit,
		(res_valid_q && res_q.command == kesd_pkg::ACT_EXIT),
		(res_q.edit_kind == kesd_pkg::EDIT_NONE), "quit item carries a line edit")
	`KESD_ASSERT_NOW(a_char_only_on_append,
		(res_valid_q && res_q.edit_kind != kesd_pkg::EDIT_APPEND),
		(res_q.edit_char == 8'd0), "edit char set without an append")

endmodule
